FILE: rtl/xor_checked_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// XOR-checked frame receiver: assertion macros
// Shared concurrent assertion wrappers for the checker files.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define XOR_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// Checked only while out of reset.
`define XCFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define XCFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// XOR-checked frame receiver package
// Shared constants, codes and types for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

    // payload buffer, power of two
    localparam int PAYLOAD_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [ADDR_W-1:0]    t_addr;

    localparam t_kind KIND_LINE    = 2'd0;
    localparam t_kind KIND_READ    = 2'd1;
    localparam t_kind KIND_RESTART = 2'd2;

    localparam t_cfg_idx CFG_HEADER = 2'd0;
    localparam t_cfg_idx CFG_END    = 2'd1;
    localparam t_cfg_idx CFG_MAX    = 2'd2;

    localparam t_byte HEADER_RST = 8'hAA;
    localparam t_byte END_RST    = 8'h55;
    localparam t_byte MAX_RST    = 8'd200;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_XOR  = 3'd4,
        PH_END  = 3'd5
    } t_phase;

endpackage

`default_nettype wire

FILE: rtl/xor_checked_frame_receiver.sv
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless the result channel stalls; the parser step
// and the buffer port take one line byte, one read or one restart each clock.
// Reset (synchronous, i_rst_n low): parser back to hunt, held fields zero,
// registers to 0xAA / 0x55 / 200, both stages empty. Buffer is not cleared.
// ----------------------------------------------------------------------------
// XOR-checked frame receiver
// Length-prefixed frame parser with XOR check and a payload buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checked_frame_receiver (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // configuration
    input  wire                      i_cfg_we,
    input  wire xcfr_pkg::t_cfg_idx  i_cfg_index,
    input  wire xcfr_pkg::t_byte     i_cfg_wdata,
    // input channel
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire xcfr_pkg::t_kind     i_kind,
    input  wire xcfr_pkg::t_byte     i_byte_in,
    input  wire xcfr_pkg::t_byte     i_read_index,
    // result channel
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic                     o_frame_ok,
    output xcfr_pkg::t_byte          o_frame_cmd,
    output xcfr_pkg::t_byte          o_frame_len,
    output xcfr_pkg::t_byte          o_read_byte
);
    import xcfr_pkg::*;

    // config
    t_byte  r_header, r_end, r_max;

    // input stage
    logic   r_s1_valid;
    t_kind  r_s1_kind;
    t_byte  r_s1_byte;
    t_byte  r_s1_idx;

    // parser state
    t_phase r_phase, n_phase;
    t_byte  r_cmd, n_cmd;
    t_byte  r_len, n_len;
    t_byte  r_fill, n_fill;
    t_byte  r_xor, n_xor;

    // result stage
    logic   r_out_valid;
    logic   r_out_ok;
    t_byte  r_out_cmd;
    t_byte  r_out_len;
    logic   r_out_is_read;
    t_byte  r_rd_data;

    t_byte  r_store [PAYLOAD_DEPTH];

    logic   w_out_free, w_adv, w_accept, w_line;
    logic   w_wr_en, w_frame_ok;
    t_phase w_reject_phase;
    t_byte  w_fill_inc;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_adv      = r_s1_valid && w_out_free;
    assign o_in_ready = !r_s1_valid || w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_line     = w_adv && (r_s1_kind == KIND_LINE);

    assign w_reject_phase = (r_s1_byte == r_header) ? PH_CMD : PH_HUNT;
    assign w_fill_inc     = r_fill + 8'd1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RST;
            r_end    <= END_RST;
            r_max    <= MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADER: r_header <= i_cfg_wdata;
                CFG_END:    r_end    <= i_cfg_wdata;
                CFG_MAX:    r_max    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind <= i_kind;
            r_s1_byte <= i_byte_in;
            r_s1_idx  <= i_read_index;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_line) begin
            unique case (r_phase)
                PH_CMD:  n_phase = PH_LEN;
                PH_LEN: begin
                    if (r_s1_byte > r_max) begin
                        n_phase = w_reject_phase;
                    end else if (r_s1_byte == 8'd0) begin
                        n_phase = PH_XOR;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (w_fill_inc == r_len) begin
                        n_phase = PH_XOR;
                    end
                end
                PH_XOR:  n_phase = (r_s1_byte != r_xor) ? w_reject_phase : PH_END;
                PH_END:  n_phase = (r_s1_byte == r_end) ? PH_HUNT : w_reject_phase;
                default: n_phase = (r_s1_byte == r_header) ? PH_CMD : PH_HUNT;
            endcase
        end else if (w_adv && (r_s1_kind == KIND_RESTART)) begin
            n_phase = PH_HUNT;
        end
    end

    // held fields, buffer write, frame done
    always_comb begin
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_fill     = r_fill;
        n_xor      = r_xor;
        w_wr_en    = 1'b0;
        w_frame_ok = 1'b0;
        if (w_line) begin
            unique case (r_phase)
                PH_CMD:  n_cmd = r_s1_byte;
                PH_LEN: begin
                    if (r_s1_byte <= r_max) begin
                        n_len  = r_s1_byte;
                        n_fill = 8'd0;
                        n_xor  = 8'd0;
                    end
                end
                PH_DATA: begin
                    w_wr_en = 1'b1;
                    n_xor   = r_xor ^ r_s1_byte;
                    n_fill  = w_fill_inc;
                end
                PH_END:  w_frame_ok = (r_s1_byte == r_end);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_fill  <= '0;
            r_xor   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_fill  <= n_fill;
            r_xor   <= n_xor;
        end
    end

    // payload buffer, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[ADDR_W'(r_fill)] <= r_s1_byte;
        end
        if (w_adv) begin
            r_rd_data <= r_store[ADDR_W'(r_s1_idx)];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_ok      <= w_frame_ok;
            r_out_cmd     <= w_frame_ok ? r_cmd : 8'd0;
            r_out_len     <= w_frame_ok ? r_len : 8'd0;
            r_out_is_read <= (r_s1_kind == KIND_READ);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_frame_ok  = r_out_ok;
    assign o_frame_cmd = r_out_cmd;
    assign o_frame_len = r_out_len;
    assign o_read_byte = r_out_is_read ? r_rd_data : 8'd0;

endmodule

`default_nettype wire

FILE: rtl/xcfr_checker.sv
// ----------------------------------------------------------------------------
// XOR-checked frame receiver checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xor_checked_frame_receiver_defines.svh"

module xcfr_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  o_in_ready,
    input  wire                  o_out_valid,
    input  wire                  i_out_ready,
    input  wire                  o_frame_ok,
    input  wire xcfr_pkg::t_byte o_frame_cmd,
    input  wire xcfr_pkg::t_byte o_frame_len,
    input  wire xcfr_pkg::t_byte o_read_byte
);
    import xcfr_pkg::*;

    // result stays offered until taken
    `XCFR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")

    // reset empties the result stage
    `XCFR_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // a frame result never carries read data
    `XCFR_ASSERT(a_ok_no_read, i_clk, i_rst_n, o_out_valid && o_frame_ok |-> o_read_byte == 8'd0, "frame result with read data")

    // no frame, no command or length
    `XCFR_ASSERT(a_nok_zero, i_clk, i_rst_n, o_out_valid && !o_frame_ok |-> o_frame_cmd == 8'd0 && o_frame_len == 8'd0, "stale frame fields")

    // with an empty result stage the input side is always open
    `XCFR_ASSERT(a_ready_open, i_clk, i_rst_n, !o_out_valid && $past(!o_out_valid) && $past(!i_in_valid) |-> o_in_ready, "input blocked with empty pipe")

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_frame_ok  (o_frame_ok),
    .o_frame_cmd (o_frame_cmd),
    .o_frame_len (o_frame_len),
    .o_read_byte (o_read_byte)
);

`default_nettype wire

FILE: tb/tb_xor_checked_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XOR-checked frame receiver testbench
// Drives line bytes, payload reads, restarts and unused-kind items through the
// valid/ready input channel, predicts every result with a behavioral parser
// model, and checks results in order under several register settings and
// idle/stall patterns on both channels.
// ----------------------------------------------------------------------------

module tb_xor_checked_frame_receiver;
    import xcfr_pkg::*;

    localparam t_kind KIND_UNUSED     = 2'd3;
    localparam int    ITEMS_PER_PHASE = 145;
    localparam int    NUM_PHASES      = 8;

    typedef struct packed {
        logic  ok;
        t_byte cmd;
        t_byte len;
        t_byte rd;
    } t_frame_result;

    typedef enum {FLAW_NONE, FLAW_XOR, FLAW_END, FLAW_CUT} t_frame_flaw;

    // Parser model plus the queue of results it expects from the block.
    class t_frame_tracker;
        t_byte         header_b;
        t_byte         end_b;
        t_byte         max_len;
        t_phase        phase;
        t_byte         cmd;
        t_byte         len;
        t_byte         fill;
        t_byte         xsum;
        t_byte         store [PAYLOAD_DEPTH];
        bit            written [PAYLOAD_DEPTH];
        int            written_idx [$];
        t_frame_result pending [$];
        int            errors;

        function new();
            header_b = HEADER_RST;
            end_b    = END_RST;
            max_len  = MAX_RST;
            phase    = PH_HUNT;
            cmd      = '0;
            len      = '0;
            fill     = '0;
            xsum     = '0;
            errors   = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_reg(t_cfg_idx idx, t_byte v);
            case (idx)
                CFG_HEADER: header_b = v;
                CFG_END:    end_b    = v;
                CFG_MAX:    max_len  = v;
                default: ;
            endcase
        endfunction

        // rejected byte restarts a frame if it is itself a header
        function void refuse(t_byte b);
            phase = (b == header_b) ? PH_CMD : PH_HUNT;
        endfunction

        function bit take_line(t_byte b);
            take_line = 1'b0;
            case (phase)
                PH_CMD: begin
                    cmd   = b;
                    phase = PH_LEN;
                end
                PH_LEN: begin
                    if (b > max_len) begin
                        refuse(b);
                    end else begin
                        len   = b;
                        fill  = '0;
                        xsum  = '0;
                        phase = (b == 8'd0) ? PH_XOR : PH_DATA;
                    end
                end
                PH_DATA: begin
                    store[fill] = b;
                    if (!written[fill]) begin
                        written[fill] = 1'b1;
                        written_idx.push_back(int'(fill));
                    end
                    xsum ^= b;
                    fill++;
                    if (fill == len) phase = PH_XOR;
                end
                PH_XOR: begin
                    if (b != xsum) refuse(b);
                    else phase = PH_END;
                end
                PH_END: begin
                    if (b == end_b) begin
                        phase     = PH_HUNT;
                        take_line = 1'b1;
                    end else begin
                        refuse(b);
                    end
                end
                default: phase = (b == header_b) ? PH_CMD : PH_HUNT;
            endcase
        endfunction

        function void note_item(t_kind k, t_byte b, t_byte ridx);
            t_frame_result r;
            r = '0;
            case (k)
                KIND_LINE: begin
                    if (take_line(b)) begin
                        r.ok  = 1'b1;
                        r.cmd = cmd;
                        r.len = len;
                    end
                end
                KIND_READ:    r.rd  = store[ridx];
                KIND_RESTART: phase = PH_HUNT;
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void compare_field(string name, t_byte want, t_byte got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %02h, actual %02h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s",
                         $time, "actual below");
                $display("    ok=%0b cmd=%02h len=%02h rd=%02h",
                         got.ok, got.cmd, got.len, got.rd);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("frame_ok", t_byte'(want.ok), t_byte'(got.ok));
            compare_field("frame_cmd", want.cmd, got.cmd);
            compare_field("frame_len", want.len, got.len);
            compare_field("read_byte", want.rd, got.rd);
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    t_cfg_idx cfg_index;
    t_byte    cfg_wdata;
    logic     in_valid;
    logic     in_ready;
    t_kind    in_kind;
    t_byte    in_byte;
    t_byte    in_ridx;
    logic     out_valid;
    logic     out_ready;
    logic     frame_ok;
    t_byte    frame_cmd;
    t_byte    frame_len;
    t_byte    read_byte;

    t_frame_tracker tracker;
    int             items_sent;
    int             send_idle_pct;
    int             recv_stall_pct;

    xor_checked_frame_receiver u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_kind       (in_kind),
        .i_byte_in    (in_byte),
        .i_read_index (in_ridx),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_frame_ok   (frame_ok),
        .o_frame_cmd  (frame_cmd),
        .o_frame_len  (frame_len),
        .o_read_byte  (read_byte)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("xor_checked_frame_receiver test failed");
        $finish;
    end

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result({frame_ok, frame_cmd, frame_len, read_byte});
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input t_kind k, input t_byte b, input t_byte ridx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_kind  = k;
        in_byte  = b;
        in_ridx  = ridx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_item(k, b, ridx);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_line(input t_byte b);
        send_item(KIND_LINE, b, t_byte'($urandom));
    endtask

    // only entries already written are ever read
    task automatic send_read();
        int n;
        n = tracker.written_idx.size();
        if (n != 0)
            send_item(KIND_READ, t_byte'($urandom),
                      t_byte'(tracker.written_idx[$urandom_range(n - 1)]));
    endtask

    task automatic send_packet(input t_frame_flaw flaw);
        t_byte seq [$];
        t_byte x;
        t_byte b;
        int    n;
        int    lim;
        int    r;
        int    cut;
        lim = (tracker.max_len > 40) ? 40 : int'(tracker.max_len);
        r   = $urandom_range(99);
        if (r == 0)      n = tracker.max_len;
        else if (r < 20) n = $urandom_range(lim);
        else             n = $urandom_range((lim < 6) ? lim : 6);
        x   = '0;
        seq = '{tracker.header_b, t_byte'($urandom), t_byte'(n)};
        repeat (n) begin
            b = t_byte'($urandom);
            x ^= b;
            seq.push_back(b);
        end
        if (flaw == FLAW_XOR) begin
            if ($urandom_range(3) == 0 && tracker.header_b != x) x = tracker.header_b;
            else x ^= t_byte'(1 << $urandom_range(7));
        end
        seq.push_back(x);
        b = tracker.end_b;
        if (flaw == FLAW_END) begin
            if ($urandom_range(3) == 0 && tracker.header_b != b) b = tracker.header_b;
            else b ^= t_byte'(1 << $urandom_range(7));
        end
        seq.push_back(b);
        cut = (flaw == FLAW_CUT) ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (int i = 0; i < seq.size(); i++) begin
            if (i == cut) begin
                send_item(KIND_RESTART, t_byte'($urandom), t_byte'($urandom));
                break;
            end
            if ($urandom_range(99) < 4) send_read();
            send_line(seq[i]);
        end
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            send_packet(FLAW_NONE);
        end else if (r < 68) begin
            send_packet(FLAW_XOR);
        end else if (r < 74) begin
            send_packet(FLAW_END);
        end else if (r < 80) begin
            send_packet(FLAW_CUT);
        end else if (r < 85 && tracker.max_len != 8'hFF) begin
            // length above the limit
            send_line(tracker.header_b);
            send_line(t_byte'($urandom));
            send_line(t_byte'($urandom_range(int'(tracker.max_len) + 1, 255)));
        end else if (r < 91) begin
            repeat ($urandom_range(1, 4))
                send_line(($urandom_range(9) == 0) ? tracker.header_b : t_byte'($urandom));
        end else if (r < 97) begin
            repeat ($urandom_range(1, 3)) send_read();
        end else if (r < 99) begin
            send_item(KIND_UNUSED, t_byte'($urandom), t_byte'($urandom));
        end else begin
            send_item(KIND_RESTART, t_byte'($urandom), t_byte'($urandom));
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (tracker.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_byte v);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.set_reg(idx, v);
    endtask

    task automatic configure(input int p);
        t_byte h;
        t_byte e;
        t_byte m;
        h = t_byte'($urandom);
        e = t_byte'($urandom);
        m = t_byte'($urandom);
        case (p)
            1: begin h = 8'hAA; e = 8'h55; m = 8'd200; end
            2: begin h = 8'h00; e = 8'hFF; m = 8'd0;   end
            3: begin h = 8'hFF; e = 8'h00; m = 8'd255; end
            4: begin h = 8'h5A; e = 8'h5A; m = 8'd3;   end
            6: begin h = 8'h00; e = 8'h00; m = 8'd255; end
            default: ;
        endcase
        write_reg(CFG_MAX, m);
        write_reg(CFG_HEADER, h);
        write_reg(CFG_END, e);
    endtask

    initial begin
        t_byte good_frames [$];
        t_byte rejects [$];

        tracker        = new();
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_HEADER;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        in_kind        = KIND_LINE;
        in_byte        = '0;
        in_ridx        = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // extreme bytes in a good frame, then a read back
        good_frames = '{8'hAA, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'hFF, 8'h55};
        foreach (good_frames[i]) send_line(good_frames[i]);
        send_item(KIND_READ, 8'h00, 8'h01);
        // length over the limit; bad XOR equal to the header opens a new
        // zero-length frame that completes
        rejects = '{8'hAA, 8'h11, 8'hC9,
                    8'hAA, 8'h22, 8'h01, 8'h5A, 8'hAA, 8'h33, 8'h00, 8'h00, 8'h55};
        foreach (rejects[i]) send_line(rejects[i]);
        send_item(KIND_UNUSED, 8'hFF, 8'hFF);
        send_line(8'hAA);
        send_line(8'h44);
        send_item(KIND_RESTART, 8'hFF, 8'hFF);
        send_line(8'h00);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain();
                configure(p);
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            while (items_sent < (p + 1) * ITEMS_PER_PHASE) random_step();
        end

        drain();
        if (tracker.errors == 0) begin
            $display("xor_checked_frame_receiver test passed");
        end else begin
            $display("xor_checked_frame_receiver test failed");
        end
        $finish;
    end

endmodule
